[src/cmwc_pkg.sv]
// ============================================================================
// cmwc_pkg
// Shared constants and types for the CMWC4096 random generator.
// ============================================================================
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = WORD_W + MULT_W;
    localparam int SUM_W       = PROD_W + 1;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP    = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0]  GOLDEN_STEP_X2 = 32'h3c6e_f372;
    localparam logic [MULT_W-1:0]  MWC_MULT       = 15'd18782;
    localparam logic [WORD_W-1:0]  MWC_COMPLEMENT = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET    = 19'd362436;
    localparam logic [IDX_W-1:0]   INDEX_RESET    = IDX_W'(TABLE_DEPTH - 1);

    // carry can never reach this bound once a draw has gone through
    localparam logic [CARRY_W-1:0] CARRY_BOUND    = 19'd18784;

    localparam logic FUNC_DRAW   = 1'b0;
    localparam logic FUNC_RESEED = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
        logic              last;
    } fill_wr_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
        logic fix_en;
    } alu_ctl_t;

endpackage

[src/cmwc_reseed_gen.sv]
// ============================================================================
// cmwc_reseed_gen
// Produces the reseed word sequence, one table word per cycle while run is
// high, with the address and a flag on the last word.
// ============================================================================
module cmwc_reseed_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         run,
    input  logic [cmwc_pkg::WORD_W-1:0]  seed,
    output cmwc_pkg::fill_wr_t           fill
);

    logic [cmwc_pkg::IDX_W-1:0]  k_reg;
    logic [cmwc_pkg::WORD_W-1:0] seed_reg;
    logic [cmwc_pkg::WORD_W-1:0] h1_reg;
    logic [cmwc_pkg::WORD_W-1:0] h2_reg;
    logic [cmwc_pkg::WORD_W-1:0] h3_reg;
    logic [cmwc_pkg::WORD_W-1:0] word;

    always_comb
    begin
        case (k_reg)
            cmwc_pkg::IDX_W'(0): word = seed_reg;
            cmwc_pkg::IDX_W'(1): word = seed_reg + cmwc_pkg::GOLDEN_STEP;
            cmwc_pkg::IDX_W'(2): word = seed_reg + cmwc_pkg::GOLDEN_STEP_X2;
            default:             word = h3_reg ^ h2_reg ^ cmwc_pkg::GOLDEN_STEP
                                        ^ cmwc_pkg::WORD_W'(k_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (start)
        begin
            k_reg <= '0;
        end
        else if (run)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // history of the last three words written
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            seed_reg <= seed;
        end
        else if (run)
        begin
            h3_reg <= h2_reg;
            h2_reg <= h1_reg;
            h1_reg <= word;
        end
    end

    assign fill.en   = run;
    assign fill.addr = k_reg;
    assign fill.data = word;
    assign fill.last = &k_reg;

endmodule

[src/cmwc_draw_alu.sv]
// ============================================================================
// cmwc_draw_alu
// Multiply-with-carry arithmetic for one draw: multiply, add carry,
// overflow correction, complement. Holds the carry.
// ============================================================================
module cmwc_draw_alu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmwc_pkg::alu_ctl_t           ctl,
    input  logic [cmwc_pkg::WORD_W-1:0]  rd_word,
    output logic [cmwc_pkg::WORD_W-1:0]  result
);

    logic [cmwc_pkg::PROD_W-1:0]  prod_reg;
    logic [cmwc_pkg::SUM_W-1:0]   t_reg;
    logic [cmwc_pkg::WORD_W-1:0]  x_reg;
    logic [cmwc_pkg::CARRY_W-1:0] carry_reg;

    logic [cmwc_pkg::PROD_W-1:0]  prod_next;
    logic [cmwc_pkg::SUM_W-1:0]   t_next;
    logic [cmwc_pkg::SUM_W-cmwc_pkg::WORD_W-1:0] c_hi;
    logic [cmwc_pkg::WORD_W:0]    lo_sum;
    logic                         wrap;
    logic [cmwc_pkg::WORD_W-1:0]  x_next;
    logic [cmwc_pkg::CARRY_W-1:0] carry_next;

    always_comb
    begin
        prod_next  = cmwc_pkg::PROD_W'(rd_word) * cmwc_pkg::PROD_W'(cmwc_pkg::MWC_MULT);
        t_next     = cmwc_pkg::SUM_W'(prod_reg) + cmwc_pkg::SUM_W'(carry_reg);
        c_hi       = t_reg[cmwc_pkg::SUM_W-1:cmwc_pkg::WORD_W];
        lo_sum     = {1'b0, t_reg[cmwc_pkg::WORD_W-1:0]} + (cmwc_pkg::WORD_W+1)'(c_hi);
        // bump both x and carry when the low add wraps
        wrap       = lo_sum[cmwc_pkg::WORD_W];
        x_next     = lo_sum[cmwc_pkg::WORD_W-1:0] + cmwc_pkg::WORD_W'(wrap);
        carry_next = cmwc_pkg::CARRY_W'(c_hi) + cmwc_pkg::CARRY_W'(wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= cmwc_pkg::CARRY_RESET;
        end
        else if (ctl.fix_en)
        begin
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.add_en)
        begin
            t_reg <= t_next;
        end
        if (ctl.fix_en)
        begin
            x_reg <= x_next;
        end
    end

    assign result = cmwc_pkg::MWC_COMPLEMENT - x_reg;

    a_carry_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fix_en |=> carry_reg < cmwc_pkg::CARRY_BOUND)
        else $error("carry out of range after draw");

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mul_en |=> ctl.add_en ##1 ctl.fix_en)
        else $error("draw stages out of order");

endmodule

[src/cmwc4096_random_generator_unit.sv]
// ============================================================================
// cmwc4096_random_generator_unit
// Complementary multiply-with-carry generator, lag 4096, table in one RAM.
// ============================================================================
// Input channel (in_valid / in_stall, fields func and seed): func selects a
// draw or a reseed. The block takes one item at a time; in_stall is high
// while an item is in work.
// A draw reads the next table word from the RAM, multiplies,
// adds the carry, corrects and writes back; the result item is registered
// onto random_word / out_valid at write-back, and the next item can be
// accepted only after that write-back.
// A reseed writes the 4096 table words through the single RAM write port,
// one a cycle, and gives no result item; the next item is taken only after
// the last table word is written.
// The output register holds a result until out_stall is low; a draw that is
// finished while the previous result still waits holds before write-back.
// Reset clears the control, sets the carry to 362436 and the index to 4095.
// The table is not cleared: reseed before the first draw.
// ============================================================================
module cmwc4096_random_generator_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [cmwc_pkg::WORD_W-1:0]  seed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cmwc_pkg::WORD_W-1:0]  random_word
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_FIX  = 6'b001000,
        S_WR   = 6'b010000,
        S_FILL = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [cmwc_pkg::IDX_W-1:0]  idx_reg;
    logic [cmwc_pkg::IDX_W-1:0]  idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [cmwc_pkg::WORD_W-1:0] random_word_reg;

    logic [cmwc_pkg::WORD_W-1:0] mem [cmwc_pkg::TABLE_DEPTH];
    logic [cmwc_pkg::WORD_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [cmwc_pkg::IDX_W-1:0]  mem_waddr;
    logic [cmwc_pkg::WORD_W-1:0] mem_wdata;

    logic                        draw_accept;
    logic                        reseed_accept;
    logic                        out_free;
    logic                        wr_fire;
    logic [cmwc_pkg::WORD_W-1:0] alu_result;
    cmwc_pkg::fill_wr_t          fill;
    cmwc_pkg::alu_ctl_t          alu_ctl;

    assign in_stall      = (state_reg != S_IDLE);
    assign draw_accept   = in_valid && !in_stall && (func == cmwc_pkg::FUNC_DRAW);
    assign reseed_accept = in_valid && !in_stall && (func == cmwc_pkg::FUNC_RESEED);
    assign idx_next      = idx_reg + 1'b1;
    assign out_free      = !out_valid_reg || !out_stall;
    assign wr_fire       = (state_reg == S_WR) && out_free;

    assign alu_ctl.mul_en = (state_reg == S_MUL);
    assign alu_ctl.add_en = (state_reg == S_ADD);
    assign alu_ctl.fix_en = (state_reg == S_FIX);

    cmwc_reseed_gen u_reseed_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (reseed_accept),
        .run   (state_reg == S_FILL),
        .seed  (seed),
        .fill  (fill)
    );

    cmwc_draw_alu u_draw_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (alu_ctl),
        .rd_word (rd_data_reg),
        .result  (alu_result)
    );

    always_comb
    begin
        mem_we    = fill.en || wr_fire;
        mem_waddr = fill.en ? fill.addr : idx_reg;
        mem_wdata = fill.en ? fill.data : alu_result;
    end

    // lag table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (draw_accept)
        begin
            rd_data_reg <= mem[idx_next];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (draw_accept)
                begin
                    state_next = S_MUL;
                end
                else if (reseed_accept)
                begin
                    state_next = S_FILL;
                end
            end
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_FIX;
            S_FIX:   state_next = S_WR;
            S_WR:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                if (fill.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (wr_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= cmwc_pkg::INDEX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (draw_accept)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            random_word_reg <= alu_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = random_word_reg;

    a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
        draw_accept |=> idx_reg == $past(idx_next))
        else $error("index did not advance on draw");

    a_fill_keeps_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> $stable(idx_reg))
        else $error("index changed during reseed");

    a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && fill.last) |=> state_reg == S_IDLE)
        else $error("reseed did not end after last word");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire |=> out_valid && random_word == $past(alu_result))
        else $error("finished draw not presented on output");

endmodule

[sim/cmwc_checker.sv]
// ============================================================================
// cmwc_checker
// Watches both channels of the CMWC4096 generator. It keeps its own lag table,
// carry and index, predicts each draw, and compares results in order.
// ============================================================================
`timescale 1ns / 1ps

module cmwc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         func,
    input  logic [cmwc_pkg::WORD_W-1:0]  seed,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [cmwc_pkg::WORD_W-1:0]  random_word,
    output int                           errors,
    output int                           pending
);

    localparam int          LAG_WORDS   = 4096;
    localparam logic [31:0] PHI_STEP    = 32'h9e37_79b9;
    localparam logic [63:0] MULTIPLIER  = 64'd18782;
    localparam logic [31:0] COMPLEMENT  = 32'hffff_fffe;
    localparam logic [18:0] CARRY_START = 19'd362436;
    localparam logic [11:0] INDEX_START = 12'd4095;

    logic [31:0] lag_words [LAG_WORDS];
    logic [18:0] mwc_carry = CARRY_START;
    logic [11:0] lag_index = INDEX_START;
    logic [31:0] expected_words [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic fill_lag_table(input logic [31:0] s);
        lag_words[0] = s;
        lag_words[1] = s + PHI_STEP;
        lag_words[2] = s + PHI_STEP + PHI_STEP;
        for (int k = 3; k < LAG_WORDS; k++)
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI_STEP ^ 32'(k);
    endtask

    task automatic draw_next_word(output logic [31:0] word);
        logic [63:0] t;
        logic [31:0] c;
        logic [31:0] x;
        lag_index = lag_index + 12'd1;
        t = MULTIPLIER * 64'(lag_words[lag_index]) + 64'(mwc_carry);
        c = t[63:32];
        x = t[31:0] + c;
        // correct for the wrap of the low half
        if (x < c)
        begin
            x = x + 32'd1;
            c = c + 32'd1;
        end
        mwc_carry = c[18:0];
        word = COMPLEMENT - x;
        lag_words[lag_index] = word;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] word;
        logic [31:0] want;
        if (!rst_n)
        begin
            mwc_carry = CARRY_START;
            lag_index = INDEX_START;
            expected_words.delete();
            pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (func == cmwc_pkg::FUNC_RESEED)
                    fill_lag_table(seed);
                else
                begin
                    draw_next_word(word);
                    expected_words.push_back(word);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected random_word %08h", random_word));
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want)
                        report_mismatch($sformatf("random_word %08h, expected %08h",
                                                  random_word, want));
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

[sim/tb_cmwc4096_random_generator_unit.sv]
// ============================================================================
// tb_cmwc4096_random_generator_unit
// Drives reseed and draw items into the generator under changing idle and
// stall rates; the checker predicts and compares, this module gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb_cmwc4096_random_generator_unit;

    localparam int PHASE_ITEMS = 425;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_TAIL  = 12;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          func      = cmwc_pkg::FUNC_DRAW;
    logic [cmwc_pkg::WORD_W-1:0]   seed      = '0;
    logic                          out_stall = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic [cmwc_pkg::WORD_W-1:0]   random_word;

    int errors;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cmwc4096_random_generator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .seed        (seed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word)
    );

    cmwc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .seed        (seed),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word),
        .errors      (errors),
        .pending     (pending)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one item and hold it until taken; idle gaps come before it
    task automatic send_item(input logic f, input logic [cmwc_pkg::WORD_W-1:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        seed     <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_for_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [cmwc_pkg::WORD_W-1:0] pick_seed();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme seeds, draws with ignored seed fields
        send_item(cmwc_pkg::FUNC_RESEED, 32'h0000_0000);
        send_item(cmwc_pkg::FUNC_DRAW,   32'h0000_0000);
        send_item(cmwc_pkg::FUNC_DRAW,   32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_DRAW,   $urandom);
        send_item(cmwc_pkg::FUNC_RESEED, 32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_DRAW,   32'hffff_ffff);
        send_item(cmwc_pkg::FUNC_DRAW,   32'h0000_0000);
        send_item(cmwc_pkg::FUNC_DRAW,   $urandom);
        send_item(cmwc_pkg::FUNC_RESEED, 32'haaaa_aaaa);
        send_item(cmwc_pkg::FUNC_DRAW,   32'h5555_5555);
        send_item(cmwc_pkg::FUNC_RESEED, 32'h5555_5555);
        send_item(cmwc_pkg::FUNC_DRAW,   32'haaaa_aaaa);
        send_item(cmwc_pkg::FUNC_DRAW,   $urandom);
        // seed + step wraps past 2^32
        send_item(cmwc_pkg::FUNC_RESEED, 32'h61c8_8647);
        send_item(cmwc_pkg::FUNC_DRAW,   $urandom);
        send_item(cmwc_pkg::FUNC_DRAW,   $urandom);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 51; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) == 0)
                    send_item(cmwc_pkg::FUNC_RESEED, pick_seed());
                else
                    send_item(cmwc_pkg::FUNC_DRAW, $urandom);
            end
            // hold off until every pending word has come back
            wait_for_results();
        end

        stall_pct = 0;
        repeat (DRAIN_TAIL) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
